// ===== hdl/fcdb_pkg.sv =====
`timescale 1ns / 1ps

package fcdb_pkg;

    localparam int VLEN_W = 11;
    localparam int OCNT_W = 16;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int BIAS_W = 32;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;

    typedef enum logic
    {
        ACT_LOAD   = 1'b0,
        ACT_WEIGHT = 1'b1
    } action_t;

    localparam logic REG_VECTOR_LENGTH = 1'b0;
    localparam logic REG_OUTPUT_COUNT  = 1'b1;

    typedef struct packed
    {
        logic                     row_end;
        logic                     last_row;
        logic [OCNT_W-1:0]        row_index;
        logic signed [BIAS_W-1:0] bias;
    } row_tag_t;

endpackage

// ===== hdl/fcdb_src_mem.sv =====
`timescale 1ns / 1ps

module fcdb_src_mem #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [fcdb_pkg::VAL_W-1:0]      wr_data,
    input  logic                            rd_en,
    input  logic [AW-1:0]                   rd_addr,
    output logic [fcdb_pkg::VAL_W-1:0]      rd_data
);

    logic [fcdb_pkg::VAL_W-1:0] mem [DEPTH];
    logic [fcdb_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/fcdb_mac.sv =====
`timescale 1ns / 1ps

module fcdb_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [fcdb_pkg::VAL_W-1:0]      src,
    input  logic signed [fcdb_pkg::VAL_W-1:0]      weight,
    input  fcdb_pkg::row_tag_t                     tag,
    input  logic                                   out_ready,
    output logic                                   advance,
    output logic                                   out_valid,
    output logic signed [fcdb_pkg::ACC_W-1:0]      out_result,
    output logic [fcdb_pkg::OCNT_W-1:0]            out_row,
    output logic                                   out_last
);

    localparam int EXT_P = fcdb_pkg::ACC_W - fcdb_pkg::PROD_W;
    localparam int EXT_B = fcdb_pkg::ACC_W - fcdb_pkg::BIAS_W;

    logic                                 s2_valid_reg;
    logic signed [fcdb_pkg::PROD_W-1:0]   s2_prod_reg;
    fcdb_pkg::row_tag_t                   s2_tag_reg;

    logic [fcdb_pkg::ACC_W-1:0]           acc_reg;
    logic [fcdb_pkg::ACC_W-1:0]           acc_next;
    logic [fcdb_pkg::ACC_W-1:0]           acc_sum;

    logic                                 s3_valid_reg;
    logic [fcdb_pkg::ACC_W-1:0]           s3_sum_reg;
    fcdb_pkg::row_tag_t                   s3_tag_reg;

    logic                                 out_valid_reg;
    logic [fcdb_pkg::ACC_W-1:0]           out_result_reg;
    logic [fcdb_pkg::OCNT_W-1:0]          out_row_reg;
    logic                                 out_last_reg;

    // freeze the whole pipe while a finished result waits
    assign advance = !out_valid_reg || out_ready;

    assign acc_sum = acc_reg + {{EXT_P{s2_prod_reg[fcdb_pkg::PROD_W-1]}}, s2_prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            acc_next = s2_tag_reg.row_end ? '0 : acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= in_valid;
            s3_valid_reg  <= s2_valid_reg && s2_tag_reg.row_end;
            out_valid_reg <= s3_valid_reg;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_prod_reg    <= src * weight;
            s2_tag_reg     <= tag;
            s3_sum_reg     <= acc_sum;
            s3_tag_reg     <= s2_tag_reg;
            out_result_reg <= s3_sum_reg
                              + {{EXT_B{s3_tag_reg.bias[fcdb_pkg::BIAS_W-1]}}, s3_tag_reg.bias};
            out_row_reg    <= s3_tag_reg.row_index;
            out_last_reg   <= s3_tag_reg.last_row;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_row    = out_row_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== hdl/fully_connected_dot_bias.sv =====
`timescale 1ns / 1ps

// Fully connected layer with bias, one multiply-accumulate per weight request.
// Input stream (s_*): tuser[0] selects the kind of request. A load request
// writes value into the source store at element_index; a weight request
// multiplies value by the next source element and accumulates. Weights come
// in row order, vector_length per row, output_count rows per vector.
// On the last weight of a row the row bias is added and one result leaves
// on the m_* stream with its row index; tlast marks the final row.
// Throughput: one request per cycle while no result waits; the source store
// is a single-port-read memory read once per weight, which sets that rate.
// A row's last weight is registered through store read, multiply,
// accumulate and bias add before its result shows on m_tvalid.
// Loads must precede the weights that use them; a weight may follow its
// load in the very next cycle.
// Reset clears counters, accumulator and pipeline; vector_length and
// output_count return to 1. The store is not cleared.
// When m_tready is low with a result waiting, the pipe freezes and
// s_tready drops until the result is taken.
// Registers (APB, pready always high): 0x0 vector_length, 0x4 output_count.

module fully_connected_dot_bias #(
    parameter int MAX_VECTOR_LEN = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // element_index[9:0], value[25:10], bias_value[57:26]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // dot_result[47:0], row_index[63:48]
    output logic        m_tlast
);

    localparam int AW      = $clog2(MAX_VECTOR_LEN);
    localparam int CNT_LIM = (MAX_VECTOR_LEN < 2047) ? MAX_VECTOR_LEN : 2047;
    localparam int CW      = $clog2(CNT_LIM);
    localparam logic [16:0] MAX_LEN = 17'(MAX_VECTOR_LEN);

    fcdb_pkg::action_t                      in_action;
    logic [fcdb_pkg::IDX_W-1:0]             in_index;
    logic signed [fcdb_pkg::VAL_W-1:0]      in_value;
    logic signed [fcdb_pkg::BIAS_W-1:0]     in_bias;

    logic [fcdb_pkg::VLEN_W-1:0]  vlen_reg;
    logic [fcdb_pkg::OCNT_W-1:0]  ocnt_reg;
    logic                         cfg_wr;

    logic [16:0]                  eff_len;
    logic [16:0]                  eff_cnt;
    logic [16:0]                  col_plus1;
    logic [16:0]                  row_plus1;

    logic [CW-1:0]                col_reg;
    logic [CW-1:0]                col_next;
    logic [fcdb_pkg::OCNT_W-1:0]  row_reg;
    logic [fcdb_pkg::OCNT_W-1:0]  row_next;

    logic                         advance;
    logic                         accept;
    logic                         load_wr;
    logic                         weight_rd;
    fcdb_pkg::row_tag_t           tag_next;

    logic                                 s1_valid_reg;
    logic signed [fcdb_pkg::VAL_W-1:0]    s1_weight_reg;
    fcdb_pkg::row_tag_t                   s1_tag_reg;
    logic [fcdb_pkg::VAL_W-1:0]           src_data;

    logic signed [fcdb_pkg::ACC_W-1:0]    res_value;
    logic [fcdb_pkg::OCNT_W-1:0]          res_row;

    assign in_action = fcdb_pkg::action_t'(s_tuser[0]);
    assign in_index  = s_tdata[9:0];
    assign in_value  = s_tdata[25:10];
    assign in_bias   = s_tdata[57:26];

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= fcdb_pkg::VLEN_W'(1);
            ocnt_reg <= fcdb_pkg::OCNT_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                fcdb_pkg::REG_VECTOR_LENGTH: vlen_reg <= pwdata[fcdb_pkg::VLEN_W-1:0];
                fcdb_pkg::REG_OUTPUT_COUNT:  ocnt_reg <= pwdata[fcdb_pkg::OCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == fcdb_pkg::REG_OUTPUT_COUNT)
                    ? {16'b0, ocnt_reg} : {21'b0, vlen_reg};

    // effective length and count
    always_comb
    begin
        if (vlen_reg == '0)
        begin
            eff_len = 17'd1;
        end
        else if (17'(vlen_reg) > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = 17'(vlen_reg);
        end
        eff_cnt = (ocnt_reg == '0) ? 17'd1 : 17'(ocnt_reg);
    end

    assign s_tready  = advance;
    assign accept    = s_tvalid && s_tready;
    assign load_wr   = accept && (in_action == fcdb_pkg::ACT_LOAD) && (17'(in_index) < MAX_LEN);
    assign weight_rd = accept && (in_action == fcdb_pkg::ACT_WEIGHT);

    assign col_plus1 = 17'(col_reg) + 17'd1;
    assign row_plus1 = 17'(row_reg) + 17'd1;

    always_comb
    begin
        tag_next.row_end   = col_plus1 >= eff_len;
        tag_next.last_row  = row_plus1 >= eff_cnt;
        tag_next.row_index = row_reg;
        tag_next.bias      = in_bias;
        col_next = col_reg;
        row_next = row_reg;
        if (weight_rd)
        begin
            if (tag_next.row_end)
            begin
                col_next = '0;
                row_next = tag_next.last_row ? '0 : row_plus1[fcdb_pkg::OCNT_W-1:0];
            end
            else
            begin
                col_next = col_plus1[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance)
            begin
                s1_valid_reg <= weight_rd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (weight_rd)
        begin
            s1_weight_reg <= in_value;
            s1_tag_reg    <= tag_next;
        end
    end

    fcdb_src_mem #(
        .DEPTH (MAX_VECTOR_LEN)
    ) u_src_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (AW'(in_index)),
        .wr_data (in_value),
        .rd_en   (weight_rd),
        .rd_addr (AW'(col_reg)),
        .rd_data (src_data)
    );

    fcdb_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .src        (src_data),
        .weight     (s1_weight_reg),
        .tag        (s1_tag_reg),
        .out_ready  (m_tready),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_result (res_value),
        .out_row    (res_row),
        .out_last   (m_tlast)
    );

    assign m_tdata = {res_row, res_value};

`ifndef SYNTHESIS
    a_last_row_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (17'(m_tdata[63:48]) + 17'd1) >= eff_cnt)
        else $error("last-row flag on a row below the configured count");

    a_load_makes_no_work : assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_action == fcdb_pkg::ACT_LOAD) |=> !s1_valid_reg)
        else $error("load request entered the multiply pipe");

    a_stall_holds_stage : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_tag_reg))
        else $error("first stage lost its weight during a stall");
`endif

endmodule

// ===== sim/fully_connected_dot_bias_tb.sv =====
`timescale 1ns / 1ps

module fully_connected_dot_bias_tb;

    localparam int STORE_DEPTH = 1024;
    localparam int FILL_LEN    = 100;
    localparam int SETTLE      = 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 1100;
    localparam int MAX_PRINTS  = 50;
    localparam int DIR_ROWS    = 27;

    typedef struct packed
    {
        logic [fcdb_pkg::ACC_W-1:0]  dot;
        logic [fcdb_pkg::OCNT_W-1:0] row;
        logic                        last;
    } fc_result_t;

    typedef struct packed
    {
        logic                        is_cfg;
        logic                        cfg_sel;
        logic [31:0]                 cfg_data;
        fcdb_pkg::action_t           act;
        logic [fcdb_pkg::IDX_W-1:0]  idx;
        logic [fcdb_pkg::VAL_W-1:0]  val;
        logic [fcdb_pkg::BIAS_W-1:0] bias;
        logic                        typed;
        fc_result_t                  want;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    // private copy of the layer state
    logic [fcdb_pkg::VAL_W-1:0]  src_copy [STORE_DEPTH];
    logic [fcdb_pkg::ACC_W-1:0]  acc_copy  = '0;
    int unsigned                 col_pos   = 0;
    int unsigned                 row_pos   = 0;
    logic [fcdb_pkg::VLEN_W-1:0] vlen_copy = fcdb_pkg::VLEN_W'(1);
    logic [fcdb_pkg::OCNT_W-1:0] ocnt_copy = fcdb_pkg::OCNT_W'(1);

    fc_result_t  pending_dots [$];
    stim_row_t   dir_tab [DIR_ROWS];
    int          errors      = 0;
    int          taken_cnt   = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          rand_items  = 0;
    int unsigned hold_left   = 0;
    int unsigned mode_left   = 0;
    int unsigned stall_mode  = 0;

    fully_connected_dot_bias dut (.*);

    always #5 clk = ~clk;

    function automatic int unsigned eff_len();
        if (vlen_copy == 0)
            return 1;
        if (vlen_copy > STORE_DEPTH)
            return STORE_DEPTH;
        return 32'(vlen_copy);
    endfunction

    function automatic int unsigned eff_rows();
        return (ocnt_copy == 0) ? 1 : 32'(ocnt_copy);
    endfunction

    // Advance the state copy by one accepted request; return 1 with the row result
    // when the request closes a row.
    function automatic bit fc_predict(input fcdb_pkg::action_t act,
                                      input logic [fcdb_pkg::IDX_W-1:0] idx,
                                      input logic [fcdb_pkg::VAL_W-1:0] val,
                                      input logic [fcdb_pkg::BIAS_W-1:0] bias,
                                      output fc_result_t res);
        logic signed [fcdb_pkg::PROD_W-1:0] prod;
        res = '0;
        if (act == fcdb_pkg::ACT_LOAD)
        begin
            src_copy[idx] = val;
            return 1'b0;
        end
        prod = $signed(src_copy[col_pos[fcdb_pkg::IDX_W-1:0]]) * $signed(val);
        acc_copy = acc_copy
                   + {{(fcdb_pkg::ACC_W-fcdb_pkg::PROD_W){prod[fcdb_pkg::PROD_W-1]}}, prod};
        if (col_pos + 1 < eff_len())
        begin
            col_pos++;
            return 1'b0;
        end
        res.dot  = acc_copy
                   + {{(fcdb_pkg::ACC_W-fcdb_pkg::BIAS_W){bias[fcdb_pkg::BIAS_W-1]}}, bias};
        res.row  = row_pos[fcdb_pkg::OCNT_W-1:0];
        res.last = (row_pos + 1 >= eff_rows());
        acc_copy = '0;
        col_pos  = 0;
        row_pos  = res.last ? 0 : row_pos + 1;
        return 1'b1;
    endfunction

    function automatic stim_row_t cfg_row(input logic sel, input logic [31:0] data);
        cfg_row          = '0;
        cfg_row.is_cfg   = 1'b1;
        cfg_row.cfg_sel  = sel;
        cfg_row.cfg_data = data;
    endfunction

    function automatic stim_row_t item_row(input fcdb_pkg::action_t act,
                                           input logic [fcdb_pkg::IDX_W-1:0] idx,
                                           input logic [fcdb_pkg::VAL_W-1:0] val,
                                           input logic [fcdb_pkg::BIAS_W-1:0] bias);
        item_row      = '0;
        item_row.act  = act;
        item_row.idx  = idx;
        item_row.val  = val;
        item_row.bias = bias;
    endfunction

    function automatic stim_row_t checked_row(input logic [fcdb_pkg::VAL_W-1:0] val,
                                              input logic [fcdb_pkg::BIAS_W-1:0] bias,
                                              input logic [fcdb_pkg::ACC_W-1:0] dot,
                                              input logic [fcdb_pkg::OCNT_W-1:0] row,
                                              input logic last);
        checked_row           = item_row(fcdb_pkg::ACT_WEIGHT, '0, val, bias);
        checked_row.typed     = 1'b1;
        checked_row.want.dot  = dot;
        checked_row.want.row  = row;
        checked_row.want.last = last;
    endfunction

    function automatic logic [fcdb_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return fcdb_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [fcdb_pkg::BIAS_W-1:0] pick_bias();
        case ($urandom_range(0, 7))
            0, 1: return '0;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < MAX_PRINTS)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_request(input fcdb_pkg::action_t act,
                                input logic [fcdb_pkg::IDX_W-1:0] idx,
                                input logic [fcdb_pkg::VAL_W-1:0] val,
                                input logic [fcdb_pkg::BIAS_W-1:0] bias,
                                input bit typed = 1'b0, input fc_result_t want = '0);
        int         gap;
        fc_result_t res;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, bias, val, idx};
        s_tuser  <= act;
        burst_left--;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (fc_predict(act, idx, val, bias, res))
            pending_dots.push_back(typed ? want : res);
    endtask

    // Drop valid, wait out every pending result, then let the pipe settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (sel == fcdb_pkg::REG_VECTOR_LENGTH)
            vlen_copy = data[fcdb_pkg::VLEN_W-1:0];
        else
            ocnt_copy = data[fcdb_pkg::OCNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        fc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            taken_cnt <= taken_cnt + 1;
            if (pending_dots.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, '0);
            else
            begin
                want = pending_dots.pop_front();
                if (m_tdata[fcdb_pkg::ACC_W-1:0] !== want.dot)
                    report_mismatch("dot_result", 64'(m_tdata[fcdb_pkg::ACC_W-1:0]),
                                    64'(want.dot));
                if (m_tdata[63:48] !== want.row)
                    report_mismatch("row_index", 64'(m_tdata[63:48]), 64'(want.row));
                if (m_tlast !== want.last)
                    report_mismatch("last_row", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready && (taken_cnt == 39 || taken_cnt == 149))
        begin
            // hold off long enough for the pipe to back up into the input
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(16, 128);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("fully_connected_dot_bias_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned vl;
        int unsigned rows;
        int unsigned n_wt;
        int          pick;
        dir_tab = '{
            item_row(fcdb_pkg::ACT_LOAD, 10'd0, 16'h7FFF, 32'h0),
            checked_row(16'h7FFF, 32'h0, 48'h0000_3FFF_0001, 16'd0, 1'b1),
            item_row(fcdb_pkg::ACT_LOAD, 10'd0, 16'h8000, 32'h0),
            checked_row(16'h8000, 32'h7FFF_FFFF, 48'h0000_BFFF_FFFF, 16'd0, 1'b1),
            checked_row(16'h7FFF, 32'h8000_0000, 48'hFFFF_4000_8000, 16'd0, 1'b1),
            // zero length and zero count both act as one
            cfg_row(fcdb_pkg::REG_VECTOR_LENGTH, 32'd0),
            cfg_row(fcdb_pkg::REG_OUTPUT_COUNT, 32'd0),
            checked_row(16'h0000, 32'd5, 48'd5, 16'd0, 1'b1),
            cfg_row(fcdb_pkg::REG_VECTOR_LENGTH, 32'd3),
            cfg_row(fcdb_pkg::REG_OUTPUT_COUNT, 32'd2),
            item_row(fcdb_pkg::ACT_LOAD, 10'h3FF, 16'h5A5A, 32'hFFFF_FFFF),
            item_row(fcdb_pkg::ACT_LOAD, 10'd1, 16'h0001, 32'h0),
            item_row(fcdb_pkg::ACT_LOAD, 10'd2, 16'hFFFF, 32'h0),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'h3FF, 16'h1234, 32'h0),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h8000, 32'h0),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h7FFF, 32'h1234_5678),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h0001, 32'h0),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h0002, 32'h0),
            // shrink the row while the column is already past its new end
            cfg_row(fcdb_pkg::REG_VECTOR_LENGTH, 32'd2),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h0003, 32'hDEAD_BEEF),
            cfg_row(fcdb_pkg::REG_VECTOR_LENGTH, 32'd1),
            cfg_row(fcdb_pkg::REG_OUTPUT_COUNT, 32'hFFFF),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h4000, 32'h0),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'hC000, 32'h4000_0000),
            // shrink the count while the row position is already past it
            cfg_row(fcdb_pkg::REG_OUTPUT_COUNT, 32'd1),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h0100, 32'h0),
            item_row(fcdb_pkg::ACT_WEIGHT, 10'd0, 16'h8000, 32'h0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_cfg)
            begin
                wait_idle();
                write_reg(dir_tab[k].cfg_sel, dir_tab[k].cfg_data);
            end
            else
                send_request(dir_tab[k].act, dir_tab[k].idx, dir_tab[k].val, dir_tab[k].bias,
                             dir_tab[k].typed, dir_tab[k].want);
        end

        // Write every entry a random row can reach; later reads then hit a written entry.
        for (int i = 0; i < FILL_LEN; i++)
            send_request(fcdb_pkg::ACT_LOAD, fcdb_pkg::IDX_W'(i), pick_value(), $urandom);

        while (rand_items < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                vl = 0;
            else if (pick < 14)
                vl = $urandom_range(1, 8);
            else if (pick < 19)
                vl = $urandom_range(9, 40);
            else
                vl = $urandom_range(41, FILL_LEN);
            pick = $urandom_range(0, 19);
            rows = (pick == 0) ? 0 : (pick == 1) ? 32'hFFFF : $urandom_range(1, 4);

            wait_idle();
            if ($urandom_range(0, 3) != 0)
                write_reg(fcdb_pkg::REG_VECTOR_LENGTH, vl);
            if ($urandom_range(0, 3) != 0)
                write_reg(fcdb_pkg::REG_OUTPUT_COUNT, rows);

            // load a fresh source vector most of the time
            if ($urandom_range(0, 9) < 7)
                for (int i = 0; i < eff_len(); i++)
                begin
                    send_request(fcdb_pkg::ACT_LOAD, fcdb_pkg::IDX_W'(i), pick_value(),
                                 $urandom);
                    rand_items++;
                end

            if ($urandom_range(0, 9) == 0)
                n_wt = $urandom_range(1, eff_len() * 2 + 3);
            else if (eff_rows() > 8)
                n_wt = eff_len() * $urandom_range(1, 5);
            else
                n_wt = eff_len() * eff_rows() * $urandom_range(1, 3);

            repeat (n_wt)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_request(fcdb_pkg::ACT_LOAD, fcdb_pkg::IDX_W'($urandom),
                                 pick_value(), $urandom);
                    rand_items++;
                end
                send_request(fcdb_pkg::ACT_WEIGHT, fcdb_pkg::IDX_W'($urandom), pick_value(),
                             pick_bias());
                rand_items++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (SETTLE * 4) @(posedge clk);
        if (errors == 0)
            $display("fully_connected_dot_bias_tb OK");
        else
            $display("fully_connected_dot_bias_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fcdb_pkg.sv
hdl/fcdb_src_mem.sv
hdl/fcdb_mac.sv
hdl/fully_connected_dot_bias.sv
sim/fully_connected_dot_bias_tb.sv
